// ----- design/assert_macros.svh -----
// Assertion macros shared by the linked list manager RTL.
// Depends on nothing; defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ALM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALM_ASSERT(lbl, clk, rstn, prop)
`define ALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/alm_pkg.sv -----
// Shared constants, types and field helpers of the linked list manager.
// Used by alm_ctrl, alm_dpath and array_linked_list_manager; depends on nothing.
package alm_pkg;

    localparam int SLOTS    = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W    = $clog2(SLOTS + 1);
    localparam int STEP_W   = $clog2(SLOTS + 1);

    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [STEP_W-1:0]   t_step;
    typedef logic [KEY_BITS-1:0] t_key;

    localparam t_ptr  NULL_LINK  = PTR_W'(SLOTS);
    localparam t_step STEP_LIMIT = STEP_W'(SLOTS);

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_DELETE  = 2'd1;
    localparam logic [1:0] ACT_SEARCH  = 2'd2;
    localparam logic [1:0] ACT_DISPLAY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        SEL_INSERT,
        SEL_DELETE,
        SEL_PEND,
        SEL_CODE
    } t_out_sel;

    typedef struct packed {
        logic       start;
        logic       advance;
        logic       take;
        logic       do_insert;
        logic       do_unlink;
        logic       emit;
        t_out_sel   sel;
        logic [1:0] code;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       free_empty;
        logic       list_empty;
        logic       walk_more;
        logic       d_valid;
        logic       d_title_hit;
        logic       d_artist_hit;
        logic       pend_valid;
        logic       out_free;
    } t_stat;

    function automatic t_key key_in(input logic [31:0] v);
        logic [63:0] e;
        e = {32'd0, v};
        return e[KEY_BITS-1:0];
    endfunction

    function automatic logic [31:0] key_out(input t_key k);
        logic [63:0] e;
        e = 64'(k);
        return e[31:0];
    endfunction

    function automatic logic [3:0] slot_field(input t_ptr p);
        logic [63:0] e;
        e = 64'(p);
        return e[3:0];
    endfunction

    function automatic logic [4:0] link_field(input t_ptr p);
        logic [63:0] e;
        e = 64'(p);
        return e[4:0];
    endfunction

endpackage

// ----- design/array_linked_list_manager.sv -----
// Top level of the linked list manager: a fixed pool of slots holding one linked
// list and one free list. Insert emits its result from the decide state, waiting
// for the result register to drain. Delete, search and display walk the list one
// slot per cycle through the registered key memory read; search and display also
// pause while a reported entry waits at the output. One operation is in work at a
// time, and its last result carries the last flag. Keys are stored in their low
// KEY_BITS bits. Depends on alm_pkg, alm_ctrl, alm_dpath and assert_macros.svh.
`include "assert_macros.svh"

module array_linked_list_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_title_key,
    input  logic [31:0] i_artist_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [31:0] o_entry_title,
    output logic [31:0] o_entry_artist,
    output logic [4:0]  o_next_slot,
    output logic        o_last
);

    alm_pkg::t_cmd  w_cmd;
    alm_pkg::t_stat w_stat;

    alm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    alm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_title_key    (i_title_key),
        .i_artist_key   (i_artist_key),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_entry_title  (o_entry_title),
        .o_entry_artist (o_entry_artist),
        .o_next_slot    (o_next_slot),
        .o_last         (o_last)
    );

    `ALM_ASSERT(a_emit_room, i_clk, i_rst_n, w_cmd.emit |-> w_stat.out_free)
    `ALM_ASSERT(a_insert_slot, i_clk, i_rst_n, w_cmd.do_insert |-> !w_stat.free_empty)
    `ALM_ASSERT(a_pend_src, i_clk, i_rst_n, (w_cmd.emit && w_cmd.sel == alm_pkg::SEL_PEND) |-> w_stat.pend_valid)
    `ALM_ASSERT(a_accept_start, i_clk, i_rst_n, (i_valid && !o_stall) |-> w_cmd.start)
    `ALM_ASSERT_NEXT(a_unlink_done, i_clk, i_rst_n, w_cmd.do_unlink, !o_stall)

endmodule

// ----- design/alm_ctrl.sv -----
// Controller state machine of the linked list manager.
// Depends on alm_pkg; drives the datapath alm_dpath through t_cmd.
module alm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  alm_pkg::t_stat i_stat,
    output alm_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   is_del;
    logic   hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        is_del  = (i_stat.action == alm_pkg::ACT_DELETE);
        hit     = (i_stat.action == alm_pkg::ACT_DISPLAY) || i_stat.d_artist_hit;
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel  = alm_pkg::SEL_CODE;
        o_cmd.code = alm_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.action == alm_pkg::ACT_INSERT) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        if (i_stat.free_empty) begin
                            o_cmd.sel  = alm_pkg::SEL_CODE;
                            o_cmd.code = alm_pkg::ST_FULL;
                        end else begin
                            o_cmd.sel       = alm_pkg::SEL_INSERT;
                            o_cmd.do_insert = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else if (i_stat.list_empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        o_cmd.sel  = alm_pkg::SEL_CODE;
                        o_cmd.code = alm_pkg::ST_EMPTY;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.d_valid) begin
                    if (is_del) begin
                        if (i_stat.d_title_hit) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.last      = 1'b1;
                                o_cmd.sel       = alm_pkg::SEL_DELETE;
                                o_cmd.do_unlink = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            o_cmd.advance = 1'b1;
                        end
                    end else if (hit && i_stat.pend_valid) begin
                        if (i_stat.out_free) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.sel     = alm_pkg::SEL_PEND;
                            o_cmd.take    = 1'b1;
                            o_cmd.advance = 1'b1;
                        end
                    end else begin
                        o_cmd.take    = hit;
                        o_cmd.advance = 1'b1;
                    end
                end else if (i_stat.walk_more) begin
                    o_cmd.advance = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    if (!is_del && i_stat.pend_valid) begin
                        o_cmd.sel = alm_pkg::SEL_PEND;
                    end else begin
                        o_cmd.sel  = alm_pkg::SEL_CODE;
                        o_cmd.code = alm_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/alm_dpath.sv -----
// Datapath of the linked list manager: key memories, link store, list pointers,
// the walk pipeline and the result register. Depends on alm_pkg.
module alm_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_action,
    input  logic [31:0]    i_title_key,
    input  logic [31:0]    i_artist_key,
    input  alm_pkg::t_cmd  i_cmd,
    output alm_pkg::t_stat o_stat,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [3:0]     o_slot,
    output logic [31:0]    o_entry_title,
    output logic [31:0]    o_entry_artist,
    output logic [4:0]     o_next_slot,
    output logic           o_last
);

    alm_pkg::t_key  r_title_mem  [alm_pkg::SLOTS];
    alm_pkg::t_key  r_artist_mem [alm_pkg::SLOTS];
    alm_pkg::t_ptr  r_link       [alm_pkg::SLOTS];

    logic [1:0]     r_action;
    alm_pkg::t_key  r_tkey;
    alm_pkg::t_key  r_akey;
    alm_pkg::t_ptr  r_list_head;
    alm_pkg::t_ptr  r_free_head;
    alm_pkg::t_ptr  r_cur;
    alm_pkg::t_step r_steps;
    alm_pkg::t_ptr  r_prev;

    logic           r_d_valid;
    alm_pkg::t_ptr  r_d_slot;
    alm_pkg::t_ptr  r_d_next;
    alm_pkg::t_key  r_d_title;
    alm_pkg::t_key  r_d_artist;

    logic           r_pend_valid;
    alm_pkg::t_ptr  r_pend_slot;
    alm_pkg::t_ptr  r_pend_next;
    alm_pkg::t_key  r_pend_title;
    alm_pkg::t_key  r_pend_artist;

    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [3:0]     r_out_slot;
    logic [31:0]    r_out_title;
    logic [31:0]    r_out_artist;
    logic [4:0]     r_out_next;
    logic           r_out_last;

    alm_pkg::t_idx  cur_idx;
    alm_pkg::t_idx  free_idx;
    alm_pkg::t_idx  prev_idx;
    alm_pkg::t_idx  d_idx;
    alm_pkg::t_ptr  cur_link;
    alm_pkg::t_ptr  free_link;
    logic           walk_more;
    logic           out_free;

    assign cur_idx   = r_cur[alm_pkg::IDX_W-1:0];
    assign free_idx  = r_free_head[alm_pkg::IDX_W-1:0];
    assign prev_idx  = r_prev[alm_pkg::IDX_W-1:0];
    assign d_idx     = r_d_slot[alm_pkg::IDX_W-1:0];
    assign cur_link  = r_link[cur_idx];
    assign free_link = r_link[free_idx];
    assign walk_more = (r_cur < alm_pkg::NULL_LINK) && (r_steps < alm_pkg::STEP_LIMIT);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        o_stat.action       = r_action;
        o_stat.free_empty   = (r_free_head >= alm_pkg::NULL_LINK);
        o_stat.list_empty   = (r_list_head >= alm_pkg::NULL_LINK);
        o_stat.walk_more    = walk_more;
        o_stat.d_valid      = r_d_valid;
        o_stat.d_title_hit  = (r_d_title == r_tkey);
        o_stat.d_artist_hit = (r_d_artist == r_akey);
        o_stat.pend_valid   = r_pend_valid;
        o_stat.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            r_title_mem[free_idx]  <= r_tkey;
            r_artist_mem[free_idx] <= r_akey;
        end
        if (i_cmd.advance && walk_more) begin
            r_d_title  <= r_title_mem[cur_idx];
            r_d_artist <= r_artist_mem[cur_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head  <= alm_pkg::NULL_LINK;
            r_free_head  <= '0;
            for (int i = 0; i < alm_pkg::SLOTS; i++) begin
                r_link[i] <= alm_pkg::PTR_W'(i + 1);
            end
            r_d_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_action     <= i_action;
                r_tkey       <= alm_pkg::key_in(i_title_key);
                r_akey       <= alm_pkg::key_in(i_artist_key);
                r_cur        <= r_list_head;
                r_steps      <= '0;
                r_prev       <= alm_pkg::NULL_LINK;
                r_d_valid    <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.do_insert) begin
                r_free_head      <= free_link;
                r_link[free_idx] <= r_list_head;
                r_list_head      <= r_free_head;
            end
            if (i_cmd.advance) begin
                r_d_valid <= walk_more;
                if (walk_more) begin
                    r_d_slot <= r_cur;
                    r_d_next <= cur_link;
                    r_cur    <= cur_link;
                    r_steps  <= r_steps + 1'b1;
                end
                if (r_d_valid) begin
                    r_prev <= r_d_slot;
                end
            end
            if (i_cmd.take) begin
                r_pend_valid  <= 1'b1;
                r_pend_slot   <= r_d_slot;
                r_pend_next   <= r_d_next;
                r_pend_title  <= r_d_title;
                r_pend_artist <= r_d_artist;
            end
            if (i_cmd.do_unlink) begin
                if (r_prev >= alm_pkg::NULL_LINK) begin
                    r_list_head <= r_d_next;
                end else begin
                    r_link[prev_idx] <= r_d_next;
                end
                r_link[d_idx] <= r_free_head;
                r_free_head   <= r_d_slot;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_last  <= i_cmd.last;
                case (i_cmd.sel)
                    alm_pkg::SEL_INSERT: begin
                        r_out_status <= alm_pkg::ST_OK;
                        r_out_slot   <= alm_pkg::slot_field(r_free_head);
                        r_out_title  <= alm_pkg::key_out(r_tkey);
                        r_out_artist <= alm_pkg::key_out(r_akey);
                        r_out_next   <= alm_pkg::link_field(r_list_head);
                    end
                    alm_pkg::SEL_DELETE: begin
                        r_out_status <= alm_pkg::ST_OK;
                        r_out_slot   <= alm_pkg::slot_field(r_d_slot);
                        r_out_title  <= alm_pkg::key_out(r_d_title);
                        r_out_artist <= alm_pkg::key_out(r_d_artist);
                        r_out_next   <= alm_pkg::link_field(r_d_next);
                    end
                    alm_pkg::SEL_PEND: begin
                        r_out_status <= alm_pkg::ST_OK;
                        r_out_slot   <= alm_pkg::slot_field(r_pend_slot);
                        r_out_title  <= alm_pkg::key_out(r_pend_title);
                        r_out_artist <= alm_pkg::key_out(r_pend_artist);
                        r_out_next   <= alm_pkg::link_field(r_pend_next);
                    end
                    default: begin
                        r_out_status <= i_cmd.code;
                        r_out_slot   <= '0;
                        r_out_title  <= '0;
                        r_out_artist <= '0;
                        r_out_next   <= '0;
                    end
                endcase
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_entry_title  = r_out_title;
    assign o_entry_artist = r_out_artist;
    assign o_next_slot    = r_out_next;
    assign o_last         = r_out_last;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for array_linked_list_manager: inserts, deletes, searches
// and displays on the slot pool, checked against a behavioral copy of the song list.
// Depends on alm_pkg and the array_linked_list_manager RTL.
module tb_top;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] title;
        logic [31:0] artist;
        logic [1:0]  phase;
        logic        drain;
        logic        squeeze;
    } t_song_op;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] title;
        logic [31:0] artist;
        logic [4:0]  next_slot;
        logic        last;
    } t_entry_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_action = alm_pkg::ACT_INSERT;
    logic [31:0] i_title_key = '0;
    logic [31:0] i_artist_key = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_slot;
    logic [31:0] o_entry_title;
    logic [31:0] o_entry_artist;
    logic [4:0]  o_next_slot;
    logic        o_last;

    t_song_op   song_ops [$];
    t_entry_rec due_entries [$];

    alm_pkg::t_key  title_mem [alm_pkg::SLOTS];
    alm_pkg::t_key  artist_mem [alm_pkg::SLOTS];
    alm_pkg::t_ptr  link_mem [alm_pkg::SLOTS];
    alm_pkg::t_ptr  head_ptr;
    alm_pkg::t_ptr  free_ptr;

    logic [1:0] phase_now = 2'd0;
    logic       squeeze_req = 1'b0;
    int         hold_left = 0;
    int         err_cnt = 0;
    int         ops_taken = 0;
    int         results_seen = 0;
    int         added = 0;
    int         status_seen [4];

    array_linked_list_manager uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_title_key    (i_title_key),
        .i_artist_key   (i_artist_key),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_entry_title  (o_entry_title),
        .o_entry_artist (o_entry_artist),
        .o_next_slot    (o_next_slot),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        err_cnt++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic t_entry_rec make_entry(input alm_pkg::t_ptr s);
        t_entry_rec    rec;
        alm_pkg::t_idx si;
        si            = s[alm_pkg::IDX_W-1:0];
        rec.status    = alm_pkg::ST_OK;
        rec.slot      = s[3:0];
        rec.title     = 32'(title_mem[si]);
        rec.artist    = 32'(artist_mem[si]);
        rec.next_slot = 5'(link_mem[si]);
        rec.last      = 1'b0;
        return rec;
    endfunction

    task automatic apply_song_op(input t_song_op op);
        t_entry_rec    hits [$];
        t_entry_rec    rec;
        alm_pkg::t_ptr cur;
        alm_pkg::t_ptr prev;
        alm_pkg::t_ptr succ;
        alm_pkg::t_idx ci;
        alm_pkg::t_key tkey;
        alm_pkg::t_key akey;
        int            steps;
        logic          found;
        tkey = alm_pkg::t_key'(op.title);
        akey = alm_pkg::t_key'(op.artist);
        rec = '0;
        if (op.action == alm_pkg::ACT_INSERT) begin
            if (free_ptr >= alm_pkg::NULL_LINK) begin
                rec.status = alm_pkg::ST_FULL;
            end else begin
                cur = free_ptr;
                ci = cur[alm_pkg::IDX_W-1:0];
                free_ptr = link_mem[ci];
                title_mem[ci] = tkey;
                artist_mem[ci] = akey;
                link_mem[ci] = head_ptr;
                head_ptr = cur;
                rec = make_entry(cur);
            end
            hits.push_back(rec);
        end else if (head_ptr >= alm_pkg::NULL_LINK) begin
            rec.status = alm_pkg::ST_EMPTY;
            hits.push_back(rec);
        end else if (op.action == alm_pkg::ACT_DELETE) begin
            rec.status = alm_pkg::ST_NOT_FOUND;
            prev = alm_pkg::NULL_LINK;
            cur = head_ptr;
            steps = 0;
            found = 1'b0;
            while (!found && steps < alm_pkg::SLOTS && cur < alm_pkg::NULL_LINK) begin
                ci = cur[alm_pkg::IDX_W-1:0];
                if (title_mem[ci] == tkey) begin
                    found = 1'b1;
                    succ = link_mem[ci];
                    if (prev >= alm_pkg::NULL_LINK) begin
                        head_ptr = succ;
                    end else begin
                        link_mem[prev[alm_pkg::IDX_W-1:0]] = succ;
                    end
                    rec = make_entry(cur);
                    link_mem[ci] = free_ptr;
                    free_ptr = cur;
                end else begin
                    prev = cur;
                    cur = link_mem[ci];
                    steps++;
                end
            end
            hits.push_back(rec);
        end else begin
            cur = head_ptr;
            steps = 0;
            while (steps < alm_pkg::SLOTS && cur < alm_pkg::NULL_LINK) begin
                ci = cur[alm_pkg::IDX_W-1:0];
                if (op.action == alm_pkg::ACT_DISPLAY || artist_mem[ci] == akey) begin
                    hits.push_back(make_entry(cur));
                end
                cur = link_mem[ci];
                steps++;
            end
            if (hits.size() == 0) begin
                rec.status = alm_pkg::ST_NOT_FOUND;
                hits.push_back(rec);
            end
        end
        foreach (hits[k]) begin
            rec = hits[k];
            rec.last = (k == hits.size() - 1);
            due_entries.push_back(rec);
        end
    endtask

    task automatic add_op(input logic [1:0] action, input logic [31:0] title,
                          input logic [31:0] artist, input logic drain,
                          input logic squeeze);
        t_song_op op;
        op.action  = action;
        op.title   = title;
        op.artist  = artist;
        op.phase   = (added < 45) ? 2'd0 : ((added < 90) ? 2'd1 : 2'd2);
        op.drain   = drain;
        op.squeeze = squeeze;
        song_ops.push_back(op);
        added++;
    endtask

    // The offered transaction is always song_ops[0]; it is popped once accepted.
    always @(posedge i_clk) begin : drive_proc
        logic sq;
        logic pick;
        sq = 1'b0;
        pick = !i_valid;
        if (i_rst_n && i_valid && !o_stall) begin
            apply_song_op(song_ops[0]);
            sq = song_ops[0].squeeze;
            void'(song_ops.pop_front());
            ops_taken++;
            pick = 1'b1;
        end
        if (i_rst_n && pick) begin
            if (song_ops.size() != 0 && (!song_ops[0].drain || due_entries.size() == 0)
                    && $urandom_range(0, 99) >= ((song_ops[0].phase == 2'd0) ? 18 :
                                                 (song_ops[0].phase == 2'd1) ? 76 : 0)) begin
                i_valid      <= 1'b1;
                i_action     <= song_ops[0].action;
                i_title_key  <= song_ops[0].title;
                i_artist_key <= song_ops[0].artist;
                phase_now    <= song_ops[0].phase;
            end else begin
                i_valid <= 1'b0;
            end
        end
        squeeze_req <= sq;
    end

    always @(posedge i_clk) begin
        if (squeeze_req) begin
            hold_left <= 60;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : watch_proc
        t_entry_rec want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_entries.size() == 0) begin
                    report($sformatf("unexpected result status %0d slot %0d", o_status, o_slot));
                end else begin
                    want = due_entries.pop_front();
                    status_seen[want.status]++;
                    if (o_status !== want.status || o_slot !== want.slot
                            || o_entry_title !== want.title || o_entry_artist !== want.artist
                            || o_next_slot !== want.next_slot || o_last !== want.last) begin
                        report($sformatf(
                            "got st %0d slot %0d %h %h nx %0d l %b, want %0d %0d %h %h %0d %b",
                            o_status, o_slot, o_entry_title, o_entry_artist, o_next_slot,
                            o_last, want.status, want.slot, want.title, want.artist,
                            want.next_slot, want.last));
                    end
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(0, 99) <
                       ((phase_now == 2'd0) ? 76 : (phase_now == 2'd1) ? 18 : 0));
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [31:0] art_a;
        logic [31:0] art_b;
        logic [31:0] dup_title;
        logic [31:0] head_title;
        logic [31:0] miss_key;
        logic [31:0] title_pool [8];
        logic [31:0] artist_pool [4];
        int          roll;
        int          n;

        for (n = 0; n < alm_pkg::SLOTS; n++) begin
            title_mem[n]  = '0;
            artist_mem[n] = '0;
            link_mem[n]   = alm_pkg::t_ptr'(n + 1);
        end
        head_ptr = alm_pkg::NULL_LINK;
        free_ptr = '0;
        for (n = 0; n < 4; n++) begin
            status_seen[n] = 0;
        end

        art_a      = $urandom;
        art_b      = $urandom;
        dup_title  = $urandom;
        miss_key   = 32'h5A5A_A5A5;
        head_title = '0;
        foreach (title_pool[k]) title_pool[k] = $urandom;
        foreach (artist_pool[k]) artist_pool[k] = $urandom;

        add_op(alm_pkg::ACT_DISPLAY, '0, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DELETE, dup_title, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_SEARCH, '0, art_a, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_INSERT, '0, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_INSERT, '1, '1, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_INSERT, dup_title, art_a, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_INSERT, dup_title, art_b, 1'b0, 1'b0);
        for (n = 0; n < alm_pkg::SLOTS - 4; n++) begin
            head_title = $urandom;
            add_op(alm_pkg::ACT_INSERT, head_title, n[0] ? art_a : art_b, 1'b0, 1'b0);
        end
        add_op(alm_pkg::ACT_INSERT, miss_key, art_a, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DISPLAY, '0, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_SEARCH, '0, art_a, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_SEARCH, '0, miss_key, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DELETE, miss_key, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DELETE, dup_title, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DELETE, head_title, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DELETE, '0, '0, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_INSERT, $urandom, art_b, 1'b0, 1'b0);
        add_op(alm_pkg::ACT_DISPLAY, '0, '0, 1'b0, 1'b0);

        for (n = 0; n < 81; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                add_op(alm_pkg::ACT_INSERT,
                       ($urandom_range(0, 19) == 0) ? $urandom : title_pool[$urandom_range(0, 7)],
                       artist_pool[$urandom_range(0, 3)], added == 45 || added == 90,
                       added == 96);
            end else if (roll < 65) begin
                add_op(alm_pkg::ACT_DELETE,
                       ($urandom_range(0, 9) == 0) ? $urandom : title_pool[$urandom_range(0, 7)],
                       $urandom, added == 45 || added == 90, added == 96);
            end else if (roll < 85) begin
                add_op(alm_pkg::ACT_SEARCH, $urandom,
                       ($urandom_range(0, 6) == 0) ? $urandom : artist_pool[$urandom_range(0, 3)],
                       added == 45 || added == 90, added == 96);
            end else begin
                add_op(alm_pkg::ACT_DISPLAY, $urandom, $urandom, added == 45 || added == 90,
                       added == 96);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (song_ops.size() != 0 || due_entries.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (due_entries.size() != 0) begin
            report($sformatf("%0d expected results never arrived", due_entries.size()));
        end
        $display("Summary: %0d operations in, %0d results out (%0d full, %0d empty, %0d missing).",
                 ops_taken, results_seen, status_seen[alm_pkg::ST_FULL],
                 status_seen[alm_pkg::ST_EMPTY], status_seen[alm_pkg::ST_NOT_FOUND]);
        $display("Summary: pool filled to capacity, duplicate titles, long output hold-off.");
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
